@@ rtl/rs_enc_pkg.sv @@
// constants, field arithmetic and generator polynomial for the reed-solomon encoder
package rs_enc_pkg;

   localparam int SYMBOL_WIDTH    = 8;
   localparam int CODE_LENGTH     = 255;
   localparam int MESSAGE_SYMBOLS = 223;
   localparam int PARITY_SYMBOLS  = CODE_LENGTH - MESSAGE_SYMBOLS;
   localparam int COUNT_WIDTH     = 8;
   localparam int LEFT_WIDTH      = $clog2(PARITY_SYMBOLS);

   localparam logic [SYMBOL_WIDTH:0] FIELD_POLY = 9'h11D;

   typedef logic [SYMBOL_WIDTH-1:0] symbol_type;
   typedef logic [PARITY_SYMBOLS-1:0][SYMBOL_WIDTH-1:0] parity_type;
   typedef logic [PARITY_SYMBOLS:0][SYMBOL_WIDTH-1:0] gen_type;

   // gf(2^8) product, shift and add
   function automatic symbol_type gf_mul(input symbol_type a, input symbol_type b);
      logic [SYMBOL_WIDTH:0] x;
      symbol_type            y;
      symbol_type            acc;
      x   = {1'b0, a};
      y   = b;
      acc = '0;
      for (int k = 0; k < SYMBOL_WIDTH; k++) begin
         if (y[0]) begin
            acc = acc ^ x[SYMBOL_WIDTH-1:0];
         end
         y = y >> 1;
         x = x << 1;
         if (x[SYMBOL_WIDTH]) begin
            x = x ^ FIELD_POLY;
         end
      end
      return acc;
   endfunction

   // product of (x + alpha^i) for i = 1 .. parity symbols
   function automatic gen_type make_generator();
      gen_type    g;
      symbol_type root;
      g    = '0;
      g[0] = symbol_type'(1);
      root = symbol_type'(1);
      for (int i = 1; i <= PARITY_SYMBOLS; i++) begin
         root = gf_mul(root, symbol_type'(2));
         for (int j = i; j > 0; j--) begin
            g[j] = g[j-1] ^ gf_mul(g[j], root);
         end
         g[0] = gf_mul(g[0], root);
      end
      return g;
   endfunction

   localparam gen_type GEN_COEF = make_generator();

endpackage

@@ rtl/reed_solomon_systematic_encoder_core.sv @@
// systematic rs(255,223) encoder over gf(2^8): data pass-through and parity generation
// Message symbols are taken one per cycle while the result channel is not stalled and no
// parity is draining, highest degree first, and each appears on the result channel in the
// cycle after its transfer with tuser low. The message ends on a symbol with tlast high or
// on the 223rd symbol; the 32 parity symbols then follow on 32 further result transfers,
// highest degree first, tuser high, tlast high on the last one. While the parity symbols
// drain out of the remainder register the input is held off. Shorter messages are encoded
// as a shortened code.
module reed_solomon_systematic_encoder_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // message_symbol[7:0]
   input  logic       req_tlast,   // last_in
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // code_symbol[7:0]
   output logic       rsp_tuser,   // is_parity
   output logic       rsp_tlast    // last_out
);

   rs_enc_pkg::parity_type par_ff, par_in;
   logic [rs_enc_pkg::COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [rs_enc_pkg::LEFT_WIDTH-1:0]  left_ff, left_in;
   logic                               emit_ff, emit_in;
   logic                               out_valid_ff, out_valid_in;
   rs_enc_pkg::symbol_type             out_sym_ff, out_sym_in;
   logic                               out_parity_ff, out_parity_in;
   logic                               out_last_ff, out_last_in;

   logic                               load;
   logic                               accept;
   logic                               msg_end;
   logic [rs_enc_pkg::COUNT_WIDTH:0]   cnt_inc;
   rs_enc_pkg::symbol_type             fb;

   assign load       = !out_valid_ff || rsp_tready;
   assign req_tready = load && !emit_ff;
   assign accept     = req_tvalid && req_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_sym_ff;
   assign rsp_tuser  = out_parity_ff;
   assign rsp_tlast  = out_last_ff;

   assign cnt_inc = {1'b0, cnt_ff} + (rs_enc_pkg::COUNT_WIDTH+1)'(1);
   assign msg_end = req_tlast ||
                    (cnt_inc >= (rs_enc_pkg::COUNT_WIDTH+1)'(rs_enc_pkg::MESSAGE_SYMBOLS));
   assign fb      = req_tdata ^ par_ff[rs_enc_pkg::PARITY_SYMBOLS-1];

   always_comb begin
      par_in        = par_ff;
      cnt_in        = cnt_ff;
      left_in       = left_ff;
      emit_in       = emit_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_sym_in    = out_sym_ff;
      out_parity_in = out_parity_ff;
      out_last_in   = out_last_ff;
      if (emit_ff && load) begin
         // drain remainder, shifting zeros in clears it
         out_valid_in  = 1'b1;
         out_sym_in    = par_ff[rs_enc_pkg::PARITY_SYMBOLS-1];
         out_parity_in = 1'b1;
         out_last_in   = (left_ff == '0);
         par_in        = {par_ff[rs_enc_pkg::PARITY_SYMBOLS-2:0], rs_enc_pkg::symbol_type'(0)};
         if (left_ff == '0) begin
            emit_in = 1'b0;
         end else begin
            left_in = left_ff - rs_enc_pkg::LEFT_WIDTH'(1);
         end
      end else if (accept) begin
         out_valid_in  = 1'b1;
         out_sym_in    = req_tdata;
         out_parity_in = 1'b0;
         out_last_in   = 1'b0;
         par_in[0] = rs_enc_pkg::gf_mul(rs_enc_pkg::GEN_COEF[0], fb);
         for (int j = 1; j < rs_enc_pkg::PARITY_SYMBOLS; j++) begin
            par_in[j] = par_ff[j-1] ^ rs_enc_pkg::gf_mul(rs_enc_pkg::GEN_COEF[j], fb);
         end
         if (msg_end) begin
            cnt_in  = '0;
            emit_in = 1'b1;
            left_in = rs_enc_pkg::LEFT_WIDTH'(rs_enc_pkg::PARITY_SYMBOLS - 1);
         end else begin
            cnt_in = cnt_inc[rs_enc_pkg::COUNT_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         par_ff       <= '0;
         cnt_ff       <= '0;
         left_ff      <= '0;
         emit_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         par_ff       <= par_in;
         cnt_ff       <= cnt_in;
         left_ff      <= left_in;
         emit_ff      <= emit_in;
         out_valid_ff <= out_valid_in;
      end
      out_sym_ff    <= out_sym_in;
      out_parity_ff <= out_parity_in;
      out_last_ff   <= out_last_in;
   end

   // no message transfer while parity drains
   assert property (@(posedge clock) disable iff (reset) emit_ff |-> !req_tready)
      else $error("input taken during parity drain");

   // codeword boundary resets the symbol count
   assert property (@(posedge clock) disable iff (reset) emit_ff |-> (cnt_ff == '0))
      else $error("symbol count not cleared at message end");

   // remainder is empty once the last parity symbol has left
   assert property (@(posedge clock) disable iff (reset) $fell(emit_ff) |-> (par_ff == '0))
      else $error("remainder not cleared after parity");

   // last marker only on parity symbols
   assert property (@(posedge clock) disable iff (reset) out_last_ff && out_valid_ff
                    |-> out_parity_ff)
      else $error("last marker on a data symbol");

   // the final parity symbol ends the drain
   assert property (@(posedge clock) disable iff (reset)
                    emit_ff && load && (left_ff == '0) |=> !emit_ff && out_last_ff)
      else $error("parity drain did not end on last symbol");

endmodule

@@ tb/sv/rs_encoder_checker.sv @@
// stream monitor and codeword predictor for the reed-solomon encoder
module rs_encoder_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,
   input  logic       rsp_tuser,
   input  logic       rsp_tlast,
   output int         mismatch_count,
   output int         pending_results
);

   localparam rs_enc_pkg::symbol_type FIELD_REDUCE = 8'h1D;

   typedef struct packed {
      rs_enc_pkg::symbol_type code;
      logic                   parity;
      logic                   final_sym;
   } code_entry_type;

   code_entry_type         expected_code[$];
   rs_enc_pkg::symbol_type generator[0:rs_enc_pkg::PARITY_SYMBOLS];
   rs_enc_pkg::symbol_type remainder[0:rs_enc_pkg::PARITY_SYMBOLS-1];
   int                     taken_count;
   int                     errors = 0;

   // msb-first multiply with reduction by the field polynomial
   function automatic rs_enc_pkg::symbol_type gf_times(input rs_enc_pkg::symbol_type a,
                                                       input rs_enc_pkg::symbol_type b);
      rs_enc_pkg::symbol_type acc;
      acc = '0;
      for (int i = rs_enc_pkg::SYMBOL_WIDTH - 1; i >= 0; i--) begin
         acc = {acc[rs_enc_pkg::SYMBOL_WIDTH-2:0], 1'b0} ^
               (acc[rs_enc_pkg::SYMBOL_WIDTH-1] ? FIELD_REDUCE : '0);
         if (b[i]) begin
            acc = acc ^ a;
         end
      end
      return acc;
   endfunction

   // generator = product of (x + alpha^i), i = 1 .. parity count
   initial begin
      rs_enc_pkg::symbol_type root;
      root = 8'h01;
      for (int k = 0; k <= rs_enc_pkg::PARITY_SYMBOLS; k++) begin
         generator[k] = '0;
      end
      generator[0] = 8'h01;
      for (int i = 1; i <= rs_enc_pkg::PARITY_SYMBOLS; i++) begin
         root = gf_times(root, 8'h02);
         for (int j = i; j > 0; j--) begin
            generator[j] = generator[j-1] ^ gf_times(generator[j], root);
         end
         generator[0] = gf_times(generator[0], root);
      end
   end

   task automatic report_error(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
   endtask

   task automatic clear_remainder();
      for (int j = 0; j < rs_enc_pkg::PARITY_SYMBOLS; j++) begin
         remainder[j] = '0;
      end
      taken_count = 0;
   endtask

   // one message symbol: pass-through entry, lfsr division step, parity at message end
   task automatic absorb_symbol(input rs_enc_pkg::symbol_type sym, input logic last_sym);
      rs_enc_pkg::symbol_type feedback;
      code_entry_type         entry;
      feedback = sym ^ remainder[rs_enc_pkg::PARITY_SYMBOLS-1];
      for (int j = rs_enc_pkg::PARITY_SYMBOLS - 1; j > 0; j--) begin
         remainder[j] = remainder[j-1] ^ gf_times(generator[j], feedback);
      end
      remainder[0] = gf_times(generator[0], feedback);
      entry.code      = sym;
      entry.parity    = 1'b0;
      entry.final_sym = 1'b0;
      expected_code.push_back(entry);
      taken_count++;
      if (last_sym || taken_count >= rs_enc_pkg::MESSAGE_SYMBOLS) begin
         for (int j = rs_enc_pkg::PARITY_SYMBOLS - 1; j >= 0; j--) begin
            entry.code      = remainder[j];
            entry.parity    = 1'b1;
            entry.final_sym = (j == 0);
            expected_code.push_back(entry);
         end
         clear_remainder();
      end
   endtask

   always @(posedge clock) begin
      code_entry_type want;
      if (reset) begin
         expected_code.delete();
         clear_remainder();
      end else begin
         if (req_tvalid && req_tready) begin
            absorb_symbol(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_code.size() == 0) begin
               report_error($sformatf("transfer with nothing expected, data %h", rsp_tdata));
            end else begin
               want = expected_code.pop_front();
               if (rsp_tdata !== want.code) begin
                  report_error($sformatf("code symbol %h, expected %h", rsp_tdata, want.code));
               end
               if (rsp_tuser !== want.parity) begin
                  report_error($sformatf("parity flag %b, expected %b", rsp_tuser,
                                         want.parity));
               end
               if (rsp_tlast !== want.final_sym) begin
                  report_error($sformatf("last flag %b, expected %b", rsp_tlast,
                                         want.final_sym));
               end
            end
         end
      end
      pending_results <= expected_code.size();
      mismatch_count  <= errors;
   end

endmodule

@@ tb/sv/testbench.sv @@
// top of the reed-solomon encoder testbench: clock, reset, stimulus and verdict
module testbench;

   localparam int IDLE_PCT    = 21;
   localparam int ITEM_TARGET = 420;
   localparam int HOLD_AT     = 150;
   localparam int HOLD_CYCLES = 300;
   localparam int CALM_FROM   = 250;
   localparam int CALM_TO     = 340;
   localparam int FULL_MSG_NO = 6;
   localparam int DRAIN_MSG_NO = 12;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // message_symbol[7:0]
   logic       req_tlast;   // last_in
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;   // code_symbol[7:0]
   logic       rsp_tuser;   // is_parity
   logic       rsp_tlast;   // last_out

   int mismatch_count;
   int pending_results;
   int sent_count = 0;

   always #4 clock = ~clock;

   reed_solomon_systematic_encoder_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   rs_encoder_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   function automatic bit calm_window();
      return sent_count >= CALM_FROM && sent_count < CALM_TO;
   endfunction

   task automatic send_symbol(input rs_enc_pkg::symbol_type sym, input logic last_sym);
      if (!calm_window()) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sym;
      req_tlast  <= last_sym;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      sent_count++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) begin
         @(posedge clock);
      end
   endtask

   // result side: random backpressure, one long hold-off, one stretch always ready
   initial begin
      bit held;
      held       = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && sent_count >= HOLD_AT) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (calm_window()) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   initial begin
      int msg_no;
      int msg_len;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // single-symbol messages at the data extremes
      send_symbol(8'h00, 1'b1);
      send_symbol(8'hFF, 1'b1);
      // walking one through a shortened codeword
      for (int b = 0; b < rs_enc_pkg::SYMBOL_WIDTH; b++) begin
         send_symbol(rs_enc_pkg::symbol_type'(1) << b, b == rs_enc_pkg::SYMBOL_WIDTH - 1);
      end
      // all-zero message gives all-zero parity
      send_symbol(8'h00, 1'b0);
      send_symbol(8'h00, 1'b0);
      send_symbol(8'h00, 1'b1);
      send_symbol(8'hAA, 1'b0);
      send_symbol(8'h55, 1'b1);
      wait_drained();

      // random messages, mostly short, one at full length ending on the count
      msg_no = 0;
      while (sent_count < ITEM_TARGET) begin
         msg_no++;
         if (msg_no == DRAIN_MSG_NO) begin
            wait_drained();
         end
         if (msg_no == FULL_MSG_NO) begin
            msg_len = rs_enc_pkg::MESSAGE_SYMBOLS;
         end else if ($urandom_range(7) == 0) begin
            msg_len = $urandom_range(70, 25);
         end else begin
            msg_len = $urandom_range(20, 1);
         end
         for (int i = 0; i < msg_len; i++) begin
            if (msg_len == rs_enc_pkg::MESSAGE_SYMBOLS) begin
               send_symbol(rs_enc_pkg::symbol_type'($urandom_range(255)),
                           (i == msg_len - 1) ? 1'($urandom_range(1)) : 1'b0);
            end else begin
               send_symbol(rs_enc_pkg::symbol_type'($urandom_range(255)), i == msg_len - 1);
            end
         end
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #(8 * 200000);
      $display("status: fail");
      $finish;
   end

endmodule

@@ reed_solomon_systematic_encoder_core.f @@
rtl/rs_enc_pkg.sv
rtl/reed_solomon_systematic_encoder_core.sv
tb/sv/rs_encoder_checker.sv
tb/sv/testbench.sv
